// File: design/msl_pkg.sv
// ----------------------------------------------------------------------------
// msl_pkg
// Shared types and constants for the multi-species life cell next-state pipe.
// ----------------------------------------------------------------------------
package msl_pkg;

	localparam int STATE_W     = 2;
	localparam int NEIGHBORS   = 8;
	localparam int MASK_W      = 9;
	localparam int REG_W       = 27;
	localparam int MODE_W      = 2;
	localparam int COUNT_W     = 4;
	localparam int SPECIES     = (1 << STATE_W) - 1;
	localparam int RULES       = 3;
	// rules that own a state code and a mask slice in the registers
	localparam int ACTIVE_RULES = (RULES < SPECIES) ? RULES : SPECIES;

	localparam int MODE_REPLACE_BIT = 0;
	localparam int MODE_LOWEST_BIT  = 1;

	typedef enum logic [1:0] {
		REG_BORN = 2'd0,
		REG_STAY = 2'd1,
		REG_MODE = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [STATE_W-1:0]              center;
		logic [SPECIES:1][COUNT_W-1:0]   count;
	} count_word_t;

	typedef struct packed {
		logic [STATE_W-1:0] center;
		logic [SPECIES:1]   born;
		logic               stays;
	} test_word_t;

endpackage

// File: design/msl_count.sv
// ----------------------------------------------------------------------------
// msl_count
// First stage: count the neighbors in each rule's state.
// ----------------------------------------------------------------------------
module msl_count (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               advance,
	input  logic                               valid,
	input  logic [msl_pkg::STATE_W-1:0]        cell_state,
	input  logic [msl_pkg::NEIGHBORS-1:0][msl_pkg::STATE_W-1:0] neighbors,
	output logic                               valid_s1,
	output msl_pkg::count_word_t               word_s1
);

	msl_pkg::count_word_t word;

	always_comb begin
		word.center = cell_state;
		word.count  = '0;
		for (int j = 1; j <= msl_pkg::SPECIES; j++) begin
			for (int i = 0; i < msl_pkg::NEIGHBORS; i++) begin
				if (neighbors[i] == msl_pkg::STATE_W'(j)) begin
					word.count[j] = word.count[j] + msl_pkg::COUNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_s1 <= word;
		end
	end

endmodule

// File: design/msl_test.sv
// ----------------------------------------------------------------------------
// msl_test
// Second stage: look up the birth and survival mask bits for each rule.
// ----------------------------------------------------------------------------
module msl_test (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic [msl_pkg::REG_W-1:0]    born_masks,
	input  logic [msl_pkg::REG_W-1:0]    stay_masks,
	input  logic                         valid_s1,
	input  msl_pkg::count_word_t         word_s1,
	output logic                         valid_s2,
	output msl_pkg::test_word_t          word_s2
);

	msl_pkg::test_word_t word;
	logic [msl_pkg::SPECIES:1] stay_bit;
	logic [msl_pkg::SPECIES:1][msl_pkg::MASK_W-1:0] born_row;
	logic [msl_pkg::SPECIES:1][msl_pkg::MASK_W-1:0] stay_row;

	always_comb begin
		word.center = word_s1.center;
		word.born   = '0;
		stay_bit    = '0;
		born_row    = '0;
		stay_row    = '0;
		for (int j = 1; j <= msl_pkg::ACTIVE_RULES; j++) begin
			born_row[j]  = born_masks[msl_pkg::MASK_W*(j-1) +: msl_pkg::MASK_W];
			stay_row[j]  = stay_masks[msl_pkg::MASK_W*(j-1) +: msl_pkg::MASK_W];
			// birth at zero neighbors never happens
			word.born[j] = (word_s1.count[j] != '0) && born_row[j][word_s1.count[j]];
			stay_bit[j]  = stay_row[j][word_s1.count[j]];
		end
		word.stays = 1'b0;
		for (int j = 1; j <= msl_pkg::ACTIVE_RULES; j++) begin
			if (word_s1.center == msl_pkg::STATE_W'(j)) begin
				word.stays = stay_bit[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_s2 <= word;
		end
	end

endmodule

// File: design/msl_resolve.sv
// ----------------------------------------------------------------------------
// msl_resolve
// Third stage: pick the winning rule and settle the next cell state.
// ----------------------------------------------------------------------------
module msl_resolve (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic [msl_pkg::MODE_W-1:0]   collision_mode,
	input  logic                         valid_s2,
	input  msl_pkg::test_word_t          word_s2,
	output logic                         valid_s3,
	output logic [msl_pkg::STATE_W-1:0]  next_state_s3
);

	logic [1:0]                  born_n;
	logic [msl_pkg::STATE_W-1:0] first;
	logic [msl_pkg::STATE_W-1:0] win;
	logic [msl_pkg::STATE_W-1:0] next;
	logic                        has_win;

	always_comb begin
		born_n = 2'($countones(word_s2.born));
		first  = '0;
		for (int j = msl_pkg::SPECIES; j >= 1; j--) begin
			if (word_s2.born[j]) begin
				first = msl_pkg::STATE_W'(j);
			end
		end
		has_win = collision_mode[msl_pkg::MODE_LOWEST_BIT] ? (born_n != 2'd0)
		                                                   : (born_n == 2'd1);
		win = has_win ? first : '0;

		if (word_s2.center == '0) begin
			next = win;
		end else if (int'(word_s2.center) > msl_pkg::RULES) begin
			next = word_s2.center;
		end else if (!word_s2.stays) begin
			next = (win == word_s2.center) ? '0 : win;
		end else if (collision_mode[msl_pkg::MODE_REPLACE_BIT] && (win != '0) &&
		             (win != word_s2.center)) begin
			next = win;
		end else begin
			next = word_s2.center;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			next_state_s3 <= next;
		end
	end

endmodule

// File: design/multi_species_life_cell_next_state.sv
// ----------------------------------------------------------------------------
// multi_species_life_cell_next_state
// Next state of one cell of a multi-species life-like automaton, three stages.
// ----------------------------------------------------------------------------
//
//   channel   handshake               payload
//   -------   ---------------------   ---------------------------------------
//   request   req_valid / req_stall   cell_state, neighbor_0 .. neighbor_7
//   response  rsp_valid / rsp_stall   next_state
//   config    cfg_we                  cfg_index, cfg_data
//
// An accepted request word reaches the response through the three pipeline
// registers; one word is accepted per cycle unless req_stall is high.
// Stages: neighbor count, mask lookup, winner and next-state resolve.
// A stalled response holds in the output register; a stage advances whenever
// its own register is empty or the stage after it moves, so bubbles fill under a stall.
// arst_n clears the valid bits and the configuration registers.
// ----------------------------------------------------------------------------
module multi_species_life_cell_next_state (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [msl_pkg::REG_W-1:0]          cfg_data,
	// request channel
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [msl_pkg::STATE_W-1:0]        cell_state,
	input  logic [msl_pkg::STATE_W-1:0]        neighbor_0,
	input  logic [msl_pkg::STATE_W-1:0]        neighbor_1,
	input  logic [msl_pkg::STATE_W-1:0]        neighbor_2,
	input  logic [msl_pkg::STATE_W-1:0]        neighbor_3,
	input  logic [msl_pkg::STATE_W-1:0]        neighbor_4,
	input  logic [msl_pkg::STATE_W-1:0]        neighbor_5,
	input  logic [msl_pkg::STATE_W-1:0]        neighbor_6,
	input  logic [msl_pkg::STATE_W-1:0]        neighbor_7,
	// response channel
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [msl_pkg::STATE_W-1:0]        next_state
);

	logic [msl_pkg::REG_W-1:0]  born_masks_q;
	logic [msl_pkg::REG_W-1:0]  stay_masks_q;
	logic [msl_pkg::MODE_W-1:0] collision_mode_q;

	logic [msl_pkg::NEIGHBORS-1:0][msl_pkg::STATE_W-1:0] neighbors;

	logic                 valid_s1, valid_s2, valid_s3;
	msl_pkg::count_word_t word_s1;
	msl_pkg::test_word_t  word_s2;
	logic                 adv1, adv2, adv3;

	// Configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			born_masks_q     <= '0;
			stay_masks_q     <= '0;
			collision_mode_q <= '0;
		end else if (cfg_we) begin
			case (msl_pkg::cfg_reg_t'(cfg_index))
				msl_pkg::REG_BORN: born_masks_q     <= cfg_data;
				msl_pkg::REG_STAY: stay_masks_q     <= cfg_data;
				msl_pkg::REG_MODE: collision_mode_q <= cfg_data[msl_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	assign neighbors = {neighbor_7, neighbor_6, neighbor_5, neighbor_4,
	                    neighbor_3, neighbor_2, neighbor_1, neighbor_0};

	// Advance a stage when its register is empty or the next one takes it.
	assign adv3      = !rsp_stall || !valid_s3;
	assign adv2      = adv3 || !valid_s2;
	assign adv1      = adv2 || !valid_s1;
	assign req_stall = !adv1;

	msl_count u_count (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (adv1),
		.valid      (req_valid),
		.cell_state (cell_state),
		.neighbors  (neighbors),
		.valid_s1   (valid_s1),
		.word_s1    (word_s1)
	);

	msl_test u_test (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (adv2),
		.born_masks (born_masks_q),
		.stay_masks (stay_masks_q),
		.valid_s1   (valid_s1),
		.word_s1    (word_s1),
		.valid_s2   (valid_s2),
		.word_s2    (word_s2)
	);

	msl_resolve u_resolve (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (adv3),
		.collision_mode (collision_mode_q),
		.valid_s2       (valid_s2),
		.word_s2        (word_s2),
		.valid_s3       (valid_s3),
		.next_state_s3  (next_state)
	);

	assign rsp_valid = valid_s3;

`ifndef SYNTHESIS
	// The input only stalls when every stage holds a word.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && valid_s2 && valid_s3))
		else $error("request stalled with a free stage");

	// An accepted word lands in the first stage.
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> valid_s1)
		else $error("accepted word lost at stage 1");

	// A word in stage 2 that cannot move stays put.
	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !adv3) |=> (valid_s2 && $stable(word_s2)))
		else $error("stage 2 word dropped under stall");

	// A moving response side never back-pressures the request side.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_stall |-> !req_stall)
		else $error("request stalled while response flows");
`endif

endmodule

// File: dv/multi_species_life_cell_next_state_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_species_life_cell_next_state_tb
// Self-checking bench for the multi-species life cell next-state pipe. A
// directed table covers reset values, extreme masks and collision modes 0,
// 1 and 3. Random neighborhoods follow under several rule sets. Each response
// word is checked against a hand-read answer or an in-bench next-state predictor,
// with random idling and back-pressure on both channels.
// ----------------------------------------------------------------------------
module multi_species_life_cell_next_state_tb;

	// one Moore neighborhood, entry k drives neighbor_k
	typedef logic [msl_pkg::NEIGHBORS-1:0][msl_pkg::STATE_W-1:0] hood_t;

	// one row of the directed table; rows marked typed carry a hand-read answer
	typedef struct packed {
		logic [1:0]                  setup;
		logic [msl_pkg::STATE_W-1:0] center;
		hood_t                       hood;
		logic                        typed;
		logic [msl_pkg::STATE_W-1:0] want;
	} probe_t;

	typedef struct packed {
		logic [msl_pkg::REG_W-1:0]  born;
		logic [msl_pkg::REG_W-1:0]  stay;
		logic [msl_pkg::MODE_W-1:0] mode;
	} rule_set_t;

	localparam int unsigned QUIET_LIMIT   = 4000;
	localparam int unsigned HOLD_CYCLES   = 64;
	localparam int unsigned PHASES        = 9;
	localparam int unsigned PHASE_WORDS   = 190;
	localparam int unsigned TAIL_CYCLES   = 10;
	localparam int unsigned PROBES        = 22;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [1:0]                   cfg_index;
	logic [msl_pkg::REG_W-1:0]    cfg_data;
	logic                         req_valid;
	logic                         req_stall;
	logic [msl_pkg::STATE_W-1:0]  cell_state;
	logic [msl_pkg::STATE_W-1:0]  neighbor_0;
	logic [msl_pkg::STATE_W-1:0]  neighbor_1;
	logic [msl_pkg::STATE_W-1:0]  neighbor_2;
	logic [msl_pkg::STATE_W-1:0]  neighbor_3;
	logic [msl_pkg::STATE_W-1:0]  neighbor_4;
	logic [msl_pkg::STATE_W-1:0]  neighbor_5;
	logic [msl_pkg::STATE_W-1:0]  neighbor_6;
	logic [msl_pkg::STATE_W-1:0]  neighbor_7;
	logic                         rsp_valid;
	logic                         rsp_stall;
	logic [msl_pkg::STATE_W-1:0]  next_state;

	// shadow copy of the rule registers, updated only while the pipe is empty
	logic [msl_pkg::REG_W-1:0]    born_mirror;
	logic [msl_pkg::REG_W-1:0]    stay_mirror;
	logic [msl_pkg::MODE_W-1:0]   mode_mirror;

	// next states still owed by the pipe, oldest first
	logic [msl_pkg::STATE_W-1:0]  pending_next_states [$];

	int unsigned         send_idle_pct;
	int unsigned         rsp_idle_pct;
	bit                  hold_off;
	int unsigned         fail_count;

	probe_t              probes [PROBES];
	rule_set_t           rule_sets [4];

	multi_species_life_cell_next_state uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.cell_state (cell_state),
		.neighbor_0 (neighbor_0),
		.neighbor_1 (neighbor_1),
		.neighbor_2 (neighbor_2),
		.neighbor_3 (neighbor_3),
		.neighbor_4 (neighbor_4),
		.neighbor_5 (neighbor_5),
		.neighbor_6 (neighbor_6),
		.neighbor_7 (neighbor_7),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.next_state (next_state)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Build a neighborhood with n1 ones, then n2 twos, then n3 threes, rest empty.
	function automatic hood_t make_hood(input int unsigned n1, input int unsigned n2,
			input int unsigned n3);
		hood_t h;
		int unsigned k;
		for (k = 0; k < msl_pkg::NEIGHBORS; k++) begin
			if (k < n1)
				h[k] = 2'd1;
			else if (k < n1 + n2)
				h[k] = 2'd2;
			else if (k < n1 + n2 + n3)
				h[k] = 2'd3;
			else
				h[k] = 2'd0;
		end
		return h;
	endfunction

	// Predict the next state of one cell from the shadow rule registers.
	function automatic logic [msl_pkg::STATE_W-1:0] life_next_state(
			input logic [msl_pkg::STATE_W-1:0] center, input hood_t hood);
		int unsigned tally [4];
		int unsigned k;
		int unsigned j;
		logic [msl_pkg::COUNT_W-1:0] c;
		int unsigned born_cnt;
		int unsigned first_born;
		int unsigned winner;
		int unsigned verdict;
		bit survives;
		logic [msl_pkg::MASK_W-1:0] born_row;
		logic [msl_pkg::MASK_W-1:0] stay_row;
		for (k = 0; k < 4; k++)
			tally[k] = 0;
		for (k = 0; k < msl_pkg::NEIGHBORS; k++)
			tally[hood[k]]++;
		born_cnt   = 0;
		first_born = 0;
		winner     = 0;
		survives   = 1'b0;
		for (j = 1; j <= msl_pkg::ACTIVE_RULES; j++) begin
			// a rule whose slice falls off the register has empty masks
			if (msl_pkg::MASK_W * (j - 1) < msl_pkg::REG_W) begin
				born_row = born_mirror[msl_pkg::MASK_W * (j - 1) +: msl_pkg::MASK_W];
				stay_row = stay_mirror[msl_pkg::MASK_W * (j - 1) +: msl_pkg::MASK_W];
			end else begin
				born_row = '0;
				stay_row = '0;
			end
			c = msl_pkg::COUNT_W'(tally[j]);
			// no birth out of zero neighbors, whatever the mask says
			if (c != 0 && born_row[c]) begin
				born_cnt++;
				if (first_born == 0)
					first_born = j;
			end
			if (j == center)
				survives = stay_row[c];
		end
		if (mode_mirror[msl_pkg::MODE_LOWEST_BIT] ? (born_cnt >= 1) : (born_cnt == 1))
			winner = first_born;
		if (center == 0)
			verdict = winner;
		else if (center > msl_pkg::RULES)
			verdict = center;
		else if (!survives)
			verdict = (winner == center) ? 0 : winner;
		else if (mode_mirror[msl_pkg::MODE_REPLACE_BIT] && winner != 0 && winner != center)
			verdict = winner;
		else
			verdict = center;
		return msl_pkg::STATE_W'(verdict);
	endfunction

	// Offer one request word, hold it until accepted, then log what it must yield.
	task automatic offer_word(input logic [msl_pkg::STATE_W-1:0] center, input hood_t hood,
			input logic typed, input logic [msl_pkg::STATE_W-1:0] want);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid  <= 1'b1;
		cell_state <= center;
		{neighbor_7, neighbor_6, neighbor_5, neighbor_4,
		 neighbor_3, neighbor_2, neighbor_1, neighbor_0} <= hood;
		// req_valid is high here, so the stall alone decides acceptance
		do
			@(posedge clk);
		while (req_stall);
		pending_next_states.push_back(typed ? want : life_next_state(center, hood));
	endtask

	// Drop valid and wait until every owed response word has come back.
	task automatic settle_pipe();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_next_states.size() != 0)
			@(posedge clk);
	endtask

	// Write all three rule registers back to back; call only with the pipe empty.
	task automatic program_rules(input rule_set_t rs);
		cfg_we    <= 1'b1;
		cfg_index <= msl_pkg::REG_BORN;
		cfg_data  <= rs.born;
		@(posedge clk);
		cfg_index <= msl_pkg::REG_STAY;
		cfg_data  <= rs.stay;
		@(posedge clk);
		cfg_index <= msl_pkg::REG_MODE;
		cfg_data  <= msl_pkg::REG_W'(rs.mode);
		@(posedge clk);
		cfg_we      <= 1'b0;
		born_mirror  = rs.born;
		stay_mirror  = rs.stay;
		mode_mirror  = rs.mode;
	endtask

	// Response side: random stall, plus one long hold-off on request from the
	// stimulus, counted here so the sender keeps pushing while the pipe backs up.
	initial begin : response_sink
		int unsigned held;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				rsp_stall <= 1'b1;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(posedge clk);
				hold_off = 1'b0;
			end
			rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
		end
	end

	// Compare each accepted response word with the oldest owed next state.
	always @(posedge clk) begin : response_check
		logic [msl_pkg::STATE_W-1:0] want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_next_states.size() == 0) begin
				$error("next_state: unexpected word, expected none, actual %0d", next_state);
				fail_count++;
			end else begin
				want = pending_next_states.pop_front();
				if (next_state !== want) begin
					$error("next_state: expected %0d, actual %0d", want, next_state);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: end the run when neither channel moves for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		int unsigned n;
		int unsigned ph;
		int unsigned w;
		int unsigned k;
		int unsigned style;
		int unsigned level;
		logic [1:0] cur_setup;
		logic [msl_pkg::STATE_W-1:0] pick;
		logic [msl_pkg::STATE_W-1:0] center;
		hood_t hood;
		rule_set_t rs;

		// rule set 0 is the reset state; it is never written, only assumed
		rule_sets[0] = '{'0, '0, 2'd0};
		// every mask bit set, lowest rule wins and newborns replace
		rule_sets[1] = '{'1, '1, 2'd3};
		// every mask bit set, unique birth only, no replacement
		rule_sets[2] = '{'1, '1, 2'd0};
		// rule 1 B3/S2, rule 2 B36/S23, rule 3 B2 with no survival; replace on
		rule_sets[3] = '{{9'h004, 9'h048, 9'h008}, {9'h000, 9'h00C, 9'h004}, 2'd1};

		probes = '{
			// reset masks: nothing is born and nothing stays, so all go empty
			'{2'd0, 2'd0, make_hood(0, 0, 0), 1'b1, 2'd0},
			'{2'd0, 2'd3, make_hood(0, 0, 8), 1'b1, 2'd0},
			'{2'd0, 2'd1, make_hood(8, 0, 0), 1'b1, 2'd0},
			'{2'd0, 2'd2, make_hood(2, 3, 3), 1'b1, 2'd0},
			'{2'd0, 2'd3, make_hood(1, 2, 5), 1'b1, 2'd0},
			// full masks, lowest wins: birth at zero count ignored
			'{2'd1, 2'd0, make_hood(0, 0, 0), 1'b0, 2'd0},
			'{2'd1, 2'd0, make_hood(0, 8, 0), 1'b1, 2'd2},
			'{2'd1, 2'd0, make_hood(2, 2, 2), 1'b0, 2'd0},
			'{2'd1, 2'd1, make_hood(0, 3, 3), 1'b0, 2'd0},
			'{2'd1, 2'd3, make_hood(0, 0, 8), 1'b1, 2'd3},
			'{2'd1, 2'd2, make_hood(8, 0, 0), 1'b0, 2'd0},
			// full masks, unique birth: a tie leaves no winner
			'{2'd2, 2'd0, make_hood(3, 2, 0), 1'b0, 2'd0},
			'{2'd2, 2'd0, make_hood(0, 0, 5), 1'b0, 2'd0},
			'{2'd2, 2'd2, make_hood(4, 0, 0), 1'b0, 2'd0},
			'{2'd2, 2'd1, make_hood(0, 0, 0), 1'b0, 2'd0},
			// sparse rules: survive, die, die while own rule is born, tie, replace, birth
			'{2'd3, 2'd1, make_hood(2, 0, 0), 1'b0, 2'd0},
			'{2'd3, 2'd1, make_hood(1, 0, 0), 1'b0, 2'd0},
			'{2'd3, 2'd1, make_hood(3, 0, 0), 1'b0, 2'd0},
			'{2'd3, 2'd3, make_hood(3, 0, 2), 1'b0, 2'd0},
			'{2'd3, 2'd2, make_hood(3, 2, 0), 1'b0, 2'd0},
			'{2'd3, 2'd0, make_hood(0, 3, 0), 1'b0, 2'd0},
			'{2'd3, 2'd0, make_hood(0, 6, 0), 1'b0, 2'd0}
		};

		// drive every input to a known value before the first edge
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = msl_pkg::REG_BORN;
		cfg_data      = '0;
		req_valid     = 1'b0;
		cell_state    = '0;
		neighbor_0    = '0;
		neighbor_1    = '0;
		neighbor_2    = '0;
		neighbor_3    = '0;
		neighbor_4    = '0;
		neighbor_5    = '0;
		neighbor_6    = '0;
		neighbor_7    = '0;
		born_mirror   = '0;
		stay_mirror   = '0;
		mode_mirror   = '0;
		send_idle_pct = 0;
		rsp_idle_pct  = 0;
		hold_off      = 1'b0;
		fail_count    = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: reprogram whenever a row asks for another rule set,
		// always with the pipe drained first.
		cur_setup = 2'd0;
		for (n = 0; n < PROBES; n++) begin
			if (probes[n].setup != cur_setup) begin
				settle_pipe();
				cur_setup = probes[n].setup;
				program_rules(rule_sets[cur_setup]);
			end
			offer_word(probes[n].center, probes[n].hood, probes[n].typed, probes[n].want);
		end
		settle_pipe();

		// Random phases. Idling: sender light / receiver heavy, then swapped,
		// then none. Rule registers walk through extremes and random values,
		// and the collision mode cycles through all four settings.
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					rs.born = '1;
					rs.stay = '1;
				end
				1: begin
					rs.born = '0;
					rs.stay = '1;
				end
				2: begin
					rs.born = '1;
					rs.stay = '0;
				end
				default: begin
					rs.born = msl_pkg::REG_W'($urandom());
					rs.stay = msl_pkg::REG_W'($urandom());
					// thin out the masks on odd phases so births get rarer
					if (ph % 2 == 1) begin
						rs.born &= msl_pkg::REG_W'($urandom());
						rs.stay &= msl_pkg::REG_W'($urandom());
					end
				end
			endcase
			rs.mode = msl_pkg::MODE_W'(ph % 4);
			program_rules(rs);

			send_idle_pct = (ph < 3) ? 25 : (ph < 6) ? 77 : 0;
			rsp_idle_pct  = (ph < 3) ? 77 : (ph < 6) ? 25 : 0;

			// long receiver hold-off while the sender pushes flat out
			if (ph == 6)
				hold_off = 1'b1;

			for (w = 0; w < PHASE_WORDS; w++) begin
				center = msl_pkg::STATE_W'($urandom_range(3));
				style  = $urandom_range(3);
				pick   = msl_pkg::STATE_W'($urandom_range(1, 3));
				level  = $urandom_range(8);
				for (k = 0; k < msl_pkg::NEIGHBORS; k++) begin
					case (style)
						// fully random neighbors
						0: hood[k] = msl_pkg::STATE_W'($urandom_range(3));
						// one species scattered over empty cells, density by level
						1: hood[k] = ($urandom_range(7) < level) ? pick : 2'd0;
						// one species dominant over random noise
						2: hood[k] = ($urandom_range(7) < level) ?
								pick : msl_pkg::STATE_W'($urandom_range(3));
						// exactly level neighbors of one species, the rest other
						default: hood[k] = (k < level) ?
								pick : msl_pkg::STATE_W'((pick + $urandom_range(1, 3)) % 4);
					endcase
				end
				offer_word(center, hood, 1'b0, '0);
			end
			// hold the sender until every owed word is back
			settle_pipe();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
